[design/seeded_combination_hash_match_defines.svh]
// Assertion macros shared by the seeded combination hash match block
`ifndef SEEDED_COMBINATION_HASH_MATCH_DEFINES_SVH
`define SEEDED_COMBINATION_HASH_MATCH_DEFINES_SVH
// Implication checked on every clock edge outside reset
`define SCH_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset
`define SCH_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

[design/sch_pkg.sv]
// Package: word types, hash constants and helper functions
`default_nettype none
package sch_pkg;

  localparam int unsigned MaskW  = 35;
  localparam int unsigned BonusW = 4;
  localparam int unsigned RankW  = 19;

  localparam logic [63:0] MulSeed = 64'h9E3779B97F4A7C15;
  localparam logic [63:0] MulDraw = 64'hD1B54A32D192ED03;
  localparam logic [63:0] FinMulA = 64'hBF58476D1CE4E5B9;
  localparam logic [63:0] FinMulB = 64'h94D049BB133111EB;
  localparam logic [RankW-1:0] RankSpan = 19'd324632;
  localparam logic [3:0] BonusSpan = 4'd12;

  // weight of each hash byte, 256^i mod span
  localparam logic [7:0][RankW-1:0] ChunkMod = {
    RankW'((64'd1 << 56) % 64'(RankSpan)),
    RankW'((64'd1 << 48) % 64'(RankSpan)),
    RankW'((64'd1 << 40) % 64'(RankSpan)),
    RankW'((64'd1 << 32) % 64'(RankSpan)),
    RankW'((64'd1 << 24) % 64'(RankSpan)),
    RankW'((64'd1 << 16) % 64'(RankSpan)),
    RankW'((64'd1 << 8) % 64'(RankSpan)),
    RankW'(64'd1 % 64'(RankSpan))
  };

  // ceil(2^49 / span): exact quotient for any dividend below 2^30
  localparam int unsigned RecipShift = 49;
  localparam logic [30:0] RecipM =
    31'(((64'd1 << RecipShift) + 64'(RankSpan) - 64'd1) / 64'(RankSpan));

  typedef struct packed {
    logic [63:0]       seed;
    logic [63:0]       draw_number;
    logic [MaskW-1:0]  reference_mask;
    logic [BonusW-1:0] reference_bonus;
  } in_word_t;

  typedef struct packed {
    logic              hit;
    logic [MaskW-1:0]  ticket_mask;
    logic [BonusW-1:0] ticket_bonus;
  } out_word_t;

  // Binomial coefficient C(n,k) for n<=35, k<=5, zero when k>n
  function automatic logic [RankW-1:0] choose(input logic [5:0] n, input logic [2:0] k);
    logic [31:0] r;
    r = 32'd1;
    if (k > n[2:0] && n < 6'd5) begin
      if ({3'd0, k} > n) r = 32'd0;
    end
    if (r != 32'd0) begin
      for (int i = 0; i < 5; i++) begin
        if (i < int'(k)) r = r * (32'(n) - 32'(i)) / 32'(i + 1);
      end
    end
    return r[RankW-1:0];
  endfunction

endpackage
`default_nettype wire

[design/sch_mul64.sv]
// Pipelined 64x64 low-half multiplier built from 32-bit partial products
`default_nettype none
module sch_mul64 (
  input  wire logic        clk_i,
  input  wire logic [63:0] a_i,
  input  wire logic [63:0] b_i,
  output logic [63:0]      p_o
);
  logic [63:0] ll_q;
  logic [31:0] lh_q, hl_q;

  // stage one: three partial products
  always_ff @(posedge clk_i) begin
    ll_q <= 64'(a_i[31:0]) * 64'(b_i[31:0]);
    lh_q <= a_i[31:0] * b_i[63:32];
    hl_q <= a_i[63:32] * b_i[31:0];
  end

  // stage two: combine the low half
  always_ff @(posedge clk_i) begin
    p_o <= ll_q + {lh_q + hl_q, 32'd0};
  end
endmodule
`default_nettype wire

[design/sch_unrank_step.sv]
// One registered digit step of the combinatorial unranking
`default_nettype none
module sch_unrank_step
  import sch_pkg::*;
#(
  parameter logic [2:0] K = 3'd5
) (
  input  wire logic             clk_i,
  input  wire logic [RankW-1:0] rem_i,
  input  wire logic [MaskW-1:0] mask_i,
  output logic [RankW-1:0]      rem_o,
  output logic [MaskW-1:0]      mask_o
);
  logic [5:0]       pos;
  logic [RankW-1:0] sub;

  // largest pos with C(pos,K) <= rem, from constant tables
  always_comb begin
    pos = 6'(K) - 6'd1;
    sub = '0;
    for (int p = 0; p < 35; p++) begin
      if (p >= int'(K) - 1 && choose(6'(p), K) <= rem_i) begin
        pos = 6'(p);
        sub = choose(6'(p), K);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rem_o  <= rem_i - sub;
    mask_o <= mask_i | (MaskW'(1) << pos);
  end
endmodule
`default_nettype wire

[design/seeded_combination_hash_match.sv]
// Seeded combination hash match: fixed-latency pipeline, one word per cycle.
// done_o rises together with out_o at the end of 20 register stages (combine 3,
// first finalizer 6, rank fold and divide 4, unrank 5, align and output 2).
// Throughput: one word per clock; busy is always low.
// Reset clears only the valid bits; payload registers are not reset.
// Results cannot be stalled by the receiver.
`default_nettype none
`include "seeded_combination_hash_match_defines.svh"
module seeded_combination_hash_match
  import sch_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     start,
  output logic          busy,
  input  wire in_word_t in_i,
  output logic          done_o,
  output out_word_t     out_o
);
  localparam int unsigned Lat = 20;

  assign busy = 1'b0;

  // valid chain and reference side-band
  logic [Lat-1:0] vld_q;
  logic [MaskW-1:0]  rm_q [Lat-1];
  logic [BonusW-1:0] rb_q [Lat-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[Lat-2:0], start};
    end
  end

  always_ff @(posedge clk_i) begin
    rm_q[0] <= in_i.reference_mask;
    rb_q[0] <= in_i.reference_bonus;
    for (int i = 1; i < Lat - 1; i++) begin
      rm_q[i] <= rm_q[i-1];
      rb_q[i] <= rb_q[i-1];
    end
  end

  // combine: two parallel multiplies then add
  logic [63:0] ps, pd, comb_q;
  sch_mul64 u_ms (.clk_i, .a_i(in_i.seed), .b_i(MulSeed), .p_o(ps));
  sch_mul64 u_md (.clk_i, .a_i(in_i.draw_number), .b_i(MulDraw), .p_o(pd));
  always_ff @(posedge clk_i) comb_q <= ps + pd;

  // first finalizer
  logic [63:0] f1a, f1b_q, f1c, h1_q;
  sch_mul64 u_f1a (.clk_i, .a_i(comb_q ^ (comb_q >> 30)), .b_i(FinMulA), .p_o(f1a));
  always_ff @(posedge clk_i) f1b_q <= f1a ^ (f1a >> 27);
  sch_mul64 u_f1b (.clk_i, .a_i(f1b_q), .b_i(FinMulB), .p_o(f1c));
  always_ff @(posedge clk_i) h1_q <= f1c ^ (f1c >> 31);
  // h1_q valid at stage index 8

  // rank = h1 mod span: fold bytes by their weights, then reciprocal divide
  logic [26:0]      fold_q [8];
  logic [29:0]      fold_sum, fold_sum_q, fold_d_q;
  logic [60:0]      quo_q;
  logic [11:0]      quo;
  logic [29:0]      rank_full;
  logic [RankW-1:0] rank_q;

  // stage 9: byte times weight
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 8; i++) begin
      fold_q[i] <= 27'(h1_q[8*i +: 8]) * 27'(ChunkMod[i]);
    end
  end

  // stage 10: adder tree, sum stays below 2^30
  assign fold_sum = ((30'(fold_q[0]) + 30'(fold_q[1])) + (30'(fold_q[2]) + 30'(fold_q[3])))
                  + ((30'(fold_q[4]) + 30'(fold_q[5])) + (30'(fold_q[6]) + 30'(fold_q[7])));
  always_ff @(posedge clk_i) fold_sum_q <= fold_sum;

  // stage 11: quotient by reciprocal
  always_ff @(posedge clk_i) begin
    quo_q    <= 61'(fold_sum_q) * 61'(RecipM);
    fold_d_q <= fold_sum_q;
  end

  // stage 12: remainder
  assign quo       = quo_q[60:RecipShift];
  assign rank_full = fold_d_q - 30'(quo) * 30'(RankSpan);
  always_ff @(posedge clk_i) rank_q <= rank_full[RankW-1:0];
  // rank_q at stage 12

  // unrank: five registered steps, stages 13..17
  logic [RankW-1:0] rem [6];
  logic [MaskW-1:0] msk [6];
  assign rem[0] = rank_q;
  assign msk[0] = '0;
  for (genvar g = 0; g < 5; g++) begin : g_un
    sch_unrank_step #(.K(3'(5 - g))) u_st (
      .clk_i, .rem_i(rem[g]), .mask_i(msk[g]), .rem_o(rem[g+1]), .mask_o(msk[g+1])
    );
  end
  logic [MaskW-1:0] mask_q;
  always_ff @(posedge clk_i) mask_q <= msk[5];

  // second finalizer over h1 (from stage 8 to 14), then mod 12
  logic [63:0] f2a, f2b_q, f2c, h2_q;
  sch_mul64 u_f2a (.clk_i, .a_i(h1_q ^ (h1_q >> 30)), .b_i(FinMulA), .p_o(f2a));
  always_ff @(posedge clk_i) f2b_q <= f2a ^ (f2a >> 27);
  sch_mul64 u_f2b (.clk_i, .a_i(f2b_q), .b_i(FinMulB), .p_o(f2c));
  always_ff @(posedge clk_i) h2_q <= f2c ^ (f2c >> 31);
  // h2_q at stage 14; mod 12 from low two bits and mod 3 by digit folding
  logic [17:0] s3_q;
  logic [4:0]  t3_d, t3_q;
  logic [2:0]  u3;
  logic [1:0]  m3_q;
  logic [1:0]  lo2_q [3];

  // stage 15: 16-bit chunks, 2^16 = 1 mod 3
  always_ff @(posedge clk_i) begin
    s3_q <= (18'(h2_q[63:48]) + 18'(h2_q[47:32])) + (18'(h2_q[31:16]) + 18'(h2_q[15:0]));
    lo2_q[0] <= h2_q[1:0];
  end

  // stage 16: 2-bit digits, 4 = 1 mod 3
  always_comb begin
    t3_d = '0;
    for (int i = 0; i < 9; i++) t3_d = t3_d + 5'(s3_q[2*i +: 2]);
  end
  always_ff @(posedge clk_i) begin
    t3_q     <= t3_d;
    lo2_q[1] <= lo2_q[0];
  end

  // stage 17: last fold, at most 7, then subtract
  assign u3 = 3'(t3_q[4]) + 3'(t3_q[3:2]) + 3'(t3_q[1:0]);
  always_ff @(posedge clk_i) begin
    m3_q     <= (u3 >= 3'd6) ? 2'(u3 - 3'd6) : (u3 >= 3'd3) ? 2'(u3 - 3'd3) : u3[1:0];
    lo2_q[2] <= lo2_q[1];
  end

  // combine residues (stage 18)
  logic [3:0] bonus_q;
  logic [3:0] b12;
  always_comb begin
    b12 = 4'd0;
    for (int c = 0; c < 12; c++) begin
      if (2'(c % 3) == m3_q && 2'(c % 4) == lo2_q[2]) b12 = 4'(c);
    end
  end
  always_ff @(posedge clk_i) bonus_q <= b12 + 4'd1;
  // bonus_q and mask_q both at stage 18

  // output register, stage 19
  out_word_t out_q;
  always_ff @(posedge clk_i) begin
    out_q.ticket_mask  <= mask_q;
    out_q.ticket_bonus <= bonus_q;
    out_q.hit <= (mask_q == rm_q[Lat-2]) && (bonus_q == rb_q[Lat-2]);
  end
  assign out_o  = out_q;
  assign done_o = vld_q[Lat-1];

  `SCH_ASSERT_IMP(a_bonus_range, clk_i, rst_ni, done_o,
    (out_o.ticket_bonus >= 4'd1) && (out_o.ticket_bonus <= BonusSpan), "bonus out of range")
  `SCH_ASSERT_IMP(a_five_bits, clk_i, rst_ni, done_o,
    $countones(out_o.ticket_mask) == 5, "mask does not hold five bits")
  `SCH_ASSERT_NXT(a_latency, clk_i, rst_ni, vld_q[Lat-2], done_o, "valid chain broken")
endmodule
`default_nettype wire
